[rtl/sqwc_pkg.sv]
// Shared types and constants for the square wave channel with envelope.
`timescale 1ns / 1ps
`default_nettype none

package sqwc_pkg;

   // Payload and register widths
   localparam int CMD_W    = 3;
   localparam int TICK_W   = 16;
   localparam int LEN_W    = 8;
   localparam int DS_W     = 16;
   localparam int MIX_W    = 32;
   localparam int PER_W    = 11;
   localparam int TIMER_W  = PER_W + 1;
   localparam int NIB_W    = 4;
   localparam int MODE_W   = 2;
   localparam int CSR_IX_W = 3;
   localparam int CSR_W    = 11;
   localparam int STEP_W   = $clog2(MIX_W);

   // Channel constants
   localparam logic [PER_W-1:0] SILENT_BELOW = PER_W'(8);
   localparam logic [NIB_W-1:0] LEVEL_MAX    = 4'hF;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_TICKS    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ENV_CLK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LEN_CLK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEN_LOAD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

   // Register indexes
   localparam logic [CSR_IX_W-1:0] CSR_PERIOD     = 3'd0;
   localparam logic [CSR_IX_W-1:0] CSR_DUTY_THR   = 3'd1;
   localparam logic [CSR_IX_W-1:0] CSR_ENV_PERIOD = 3'd2;
   localparam logic [CSR_IX_W-1:0] CSR_ENV_MODE   = 3'd3;
   localparam logic [CSR_IX_W-1:0] CSR_LEN_EN     = 3'd4;
   localparam logic [CSR_IX_W-1:0] CSR_INV_REQ    = 3'd5;
   localparam logic [CSR_IX_W-1:0] CSR_INV_CUTOFF = 3'd6;
   localparam logic [CSR_IX_W-1:0] CSR_FIXED_VOL  = 3'd7;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEG,
      ST_ACC,
      ST_DIV_L,
      ST_DIV_R,
      ST_RSP
   } state_type;

endpackage

`default_nettype wire

[rtl/square_wave_channel_with_envelope.sv]
// Top level of the square wave sound channel: sequencer, channel state and mix sums.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken at a time; req_ready is high only while the sequencer
// is idle. Envelope clock, length clock and length load finish in the cycle
// they are accepted. A tick batch walks the period timer one segment (up to
// the next timer wrap or the end of the batch) at a time, through a segment
// step and an accumulate step; with a period below 8 the batch is dropped and
// the sequencer stays idle. A mix read runs the two sums through one shared
// bit-serial divider, left then right, 32 quotient bits each, and then loads
// the response register. The response sits in an output register, so the next
// request is accepted while it waits for rsp_ready.
// Both sums wrap at 32 bits and are cleared when the read response is loaded.
module square_wave_channel_with_envelope (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [sqwc_pkg::CMD_W-1:0]            req_command,
   input  wire logic [sqwc_pkg::TICK_W-1:0]           req_tick_count,
   input  wire logic                                  req_mix_enable,
   input  wire logic [sqwc_pkg::LEN_W-1:0]            req_length_value,
   input  wire logic [sqwc_pkg::DS_W-1:0]             req_downsample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [sqwc_pkg::MIX_W-1:0]          rsp_mix_left,
   output logic signed [sqwc_pkg::MIX_W-1:0]          rsp_mix_right,
   input  wire logic                                  csr_we,
   input  wire logic [sqwc_pkg::CSR_IX_W-1:0]         csr_index,
   input  wire logic [sqwc_pkg::CSR_W-1:0]            csr_wdata
);
   import sqwc_pkg::*;

   // Configuration registers
   logic [PER_W-1:0]  period_ff;
   logic [NIB_W-1:0]  duty_thr_ff;
   logic [NIB_W-1:0]  env_period_ff;
   logic [MODE_W-1:0] env_mode_ff;
   logic              len_en_ff;
   logic              inv_req_ff;
   logic [PER_W-1:0]  inv_cutoff_ff;
   logic [NIB_W-1:0]  fixed_vol_ff;

   // Channel state
   logic [TIMER_W-1:0] timer_ff;
   logic [NIB_W-1:0]   duty_ff;
   logic [NIB_W-1:0]   env_div_ff;
   logic [NIB_W-1:0]   env_level_ff;
   logic [NIB_W-1:0]   cur_vol_ff;
   logic [LEN_W-1:0]   len_left_ff;
   logic               inv_active_ff;
   logic [MIX_W-1:0]   sum_left_ff;
   logic [MIX_W-1:0]   sum_right_ff;

   // Sequencer and batch registers
   state_type           state_ff, state_in;
   logic [TICK_W-1:0]   ticks_ff;
   logic [TIMER_W-1:0]  seg_ff;
   logic                mix_ff;
   logic [DS_W-1:0]     ds_ff;
   logic signed [MIX_W-1:0] q_left_ff;

   // Response register
   logic                    rsp_valid_ff;
   logic signed [MIX_W-1:0] rsp_left_ff;
   logic signed [MIX_W-1:0] rsp_right_ff;

   logic                    accept;
   logic                    div_start;
   logic                    div_done;
   logic signed [MIX_W-1:0] div_dividend;
   logic [DS_W-1:0]         div_divisor;
   logic signed [MIX_W-1:0] div_quot;
   logic                    rsp_load;

   logic [NIB_W-1:0]   vol;
   logic [TIMER_W-1:0] seg_len;
   logic [TICK_W-1:0]  add;
   logic               audible;
   logic [NIB_W-1:0]   env_level_in;
   logic [NIB_W-1:0]   duty_in;

   assign accept = req_valid && req_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= '0;
         duty_thr_ff   <= NIB_W'(8);
         env_period_ff <= '0;
         env_mode_ff   <= '0;
         len_en_ff     <= 1'b0;
         inv_req_ff    <= 1'b0;
         inv_cutoff_ff <= PER_W'(2047);
         fixed_vol_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:     period_ff     <= csr_wdata;
            CSR_DUTY_THR:   duty_thr_ff   <= csr_wdata[NIB_W-1:0];
            CSR_ENV_PERIOD: env_period_ff <= csr_wdata[NIB_W-1:0];
            CSR_ENV_MODE:   env_mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_LEN_EN:     len_en_ff     <= csr_wdata[0];
            CSR_INV_REQ:    inv_req_ff    <= csr_wdata[0];
            CSR_INV_CUTOFF: inv_cutoff_ff <= csr_wdata;
            CSR_FIXED_VOL:  fixed_vol_ff  <= csr_wdata[NIB_W-1:0];
            default: ;
         endcase
      end
   end

   // Segment length, volume and accumulation term
   assign vol     = env_mode_ff[1] ? cur_vol_ff : fixed_vol_ff;
   assign seg_len = ({{(TICK_W-TIMER_W){1'b0}}, timer_ff} < ticks_ff) ?
                    timer_ff : ticks_ff[TIMER_W-1:0];
   assign add     = {{(TICK_W-NIB_W){1'b0}}, vol} *
                    {{(TICK_W-TIMER_W){1'b0}}, seg_ff};
   assign audible = mix_ff && (duty_ff < duty_thr_ff) && (len_left_ff != '0);
   assign duty_in = duty_ff + 1'b1;

   // Envelope decay step
   always_comb begin
      env_level_in = env_level_ff;
      if (env_level_ff != '0) begin
         env_level_in = env_level_ff - 1'b1;
      end else if (env_mode_ff[0]) begin
         env_level_in = LEVEL_MAX;
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and divider control
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = $signed(sum_right_ff);
      div_divisor  = ds_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            div_dividend = $signed(sum_left_ff);
            div_divisor  = req_downsample;
            if (req_valid) begin
               if (req_command == CMD_TICKS && period_ff >= SILENT_BELOW) begin
                  state_in = ST_SEG;
               end else if (req_command == CMD_READ) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_L;
               end
            end
         end
         ST_SEG: begin
            state_in = (ticks_ff == '0) ? ST_IDLE : ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_SEG;
         end
         ST_DIV_L: begin
            if (div_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (div_done) begin
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Channel state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff      <= TIMER_W'(1);
         duty_ff       <= '0;
         env_div_ff    <= '0;
         env_level_ff  <= '0;
         cur_vol_ff    <= '0;
         len_left_ff   <= '0;
         inv_active_ff <= 1'b0;
         sum_left_ff   <= '0;
         sum_right_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_command)
                     CMD_ENV_CLK: begin
                        if (env_div_ff != '0) begin
                           env_div_ff <= env_div_ff - 1'b1;
                        end else begin
                           env_div_ff   <= env_period_ff;
                           env_level_ff <= env_level_in;
                           if (env_mode_ff[1]) begin
                              cur_vol_ff <= env_level_in;
                           end
                        end
                     end
                     CMD_LEN_CLK: begin
                        if (len_en_ff && len_left_ff != '0) begin
                           len_left_ff <= len_left_ff - 1'b1;
                        end
                     end
                     CMD_LEN_LOAD: begin
                        len_left_ff <= req_length_value;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SEG: begin
               if (ticks_ff != '0) begin
                  timer_ff <= timer_ff - seg_len;
               end
            end
            ST_ACC: begin
               // accumulate, then handle a timer wrap
               if (audible) begin
                  sum_left_ff <= sum_left_ff + {{(MIX_W-TICK_W){1'b0}}, add};
                  if (inv_active_ff) begin
                     sum_right_ff <= sum_right_ff - {{(MIX_W-TICK_W){1'b0}}, add};
                  end else begin
                     sum_right_ff <= sum_right_ff + {{(MIX_W-TICK_W){1'b0}}, add};
                  end
               end
               if (timer_ff == '0) begin
                  timer_ff <= {1'b0, period_ff} + 1'b1;
                  duty_ff  <= duty_in;
                  if (duty_in == '0) begin
                     inv_active_ff <= inv_req_ff && !(inv_cutoff_ff < period_ff);
                  end
               end
            end
            ST_RSP: begin
               if (rsp_load) begin
                  sum_left_ff  <= '0;
                  sum_right_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Batch and read bookkeeping
   always_ff @(posedge clock) begin
      if (accept) begin
         ticks_ff <= req_tick_count;
         mix_ff   <= req_mix_enable;
         ds_ff    <= req_downsample;
      end else if (state_ff == ST_SEG && ticks_ff != '0) begin
         ticks_ff <= ticks_ff - {{(TICK_W-TIMER_W){1'b0}}, seg_len};
         seg_ff   <= seg_len;
      end
      if (state_ff == ST_DIV_L && div_done) begin
         q_left_ff <= div_quot;
      end
   end

   // Shared divider
   sqwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_left_ff  <= q_left_ff;
         rsp_right_ff <= div_quot;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mix_left  = rsp_left_ff;
   assign rsp_mix_right = rsp_right_ff;

   // Accumulate step always follows a segment step
   a_acc_after_seg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> ($past(state_ff) == ST_SEG))
      else $error("accumulate step without segment step");

   // Timer never rests at zero after an accumulate step
   a_timer_reload: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |=> (timer_ff != '0))
      else $error("timer left at zero");

   // Divider completes only during a read
   a_div_in_read: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_L || state_ff == ST_DIV_R))
      else $error("divider done outside a read");

   // A new response comes only from the response step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RSP))
      else $error("response raised outside response step");

   // Sums are cleared once a read response is loaded
   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (sum_left_ff == '0 && sum_right_ff == '0))
      else $error("sums not cleared after read");

endmodule

`default_nettype wire

[rtl/sqwc_div.sv]
// Radix-2 restoring divider: signed 32-bit sum over unsigned 16-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module sqwc_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [sqwc_pkg::MIX_W-1:0] dividend,
   input  wire logic [sqwc_pkg::DS_W-1:0]        divisor,
   output logic                                  done,
   output logic signed [sqwc_pkg::MIX_W-1:0]     quotient
);
   import sqwc_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] count_ff;
   logic              neg_ff;
   logic [MIX_W-1:0]  mag_ff;
   logic [DS_W-1:0]   rem_ff;
   logic [DS_W-1:0]   den_ff;

   logic [DS_W:0]     trial;
   logic [DS_W:0]     diff;
   logic              fits;

   // Shift in one dividend bit and try the subtraction
   assign trial = {rem_ff, mag_ff[MIX_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // Step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Load magnitude and divisor, then one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[MIX_W-1];
         mag_ff <= dividend[MIX_W-1] ? (~dividend + 1'b1) : dividend;
         rem_ff <= '0;
         den_ff <= (divisor == '0) ? DS_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DS_W-1:0] : trial[DS_W-1:0];
         mag_ff <= {mag_ff[MIX_W-2:0], fits};
      end
   end

   // Restore the sign: truncation toward zero
   assign quotient = neg_ff ? $signed(~mag_ff + 1'b1) : $signed(mag_ff);
   assign done     = done_ff;

endmodule

`default_nettype wire

[dv/square_wave_channel_with_envelope_tb.sv]
// Self-checking testbench for the square wave channel with envelope and length counter.
`timescale 1ns / 1ps

module square_wave_channel_with_envelope_tb;
   import sqwc_pkg::*;

   // Commands the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_READ + 3'd1;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_REQUESTS = 115;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [TICK_W-1:0] tick_count;
      logic              mix_enable;
      logic [LEN_W-1:0]  length_value;
      logic [DS_W-1:0]   downsample;
   } chan_req_type;

   typedef struct {
      logic [MIX_W-1:0] left;
      logic [MIX_W-1:0] right;
   } mix_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_command = '0;
   logic [TICK_W-1:0]       req_tick_count = '0;
   logic                    req_mix_enable = 1'b0;
   logic [LEN_W-1:0]        req_length_value = '0;
   logic [DS_W-1:0]         req_downsample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [MIX_W-1:0] rsp_mix_left;
   logic signed [MIX_W-1:0] rsp_mix_right;
   logic                    csr_we = 1'b0;
   logic [CSR_IX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   // Channel copy: registers as written, state as predicted
   logic [PER_W-1:0]   cfg_period     = '0;
   logic [NIB_W-1:0]   cfg_duty_thr   = NIB_W'(8);
   logic [NIB_W-1:0]   cfg_env_period = '0;
   logic [MODE_W-1:0]  cfg_env_mode   = '0;
   logic               cfg_len_en     = 1'b0;
   logic               cfg_inv_req    = 1'b0;
   logic [PER_W-1:0]   cfg_inv_cutoff = '1;
   logic [NIB_W-1:0]   cfg_fixed_vol  = '0;

   logic [TIMER_W-1:0] timer_left = TIMER_W'(1);
   logic [NIB_W-1:0]   duty_pos   = '0;
   logic [NIB_W-1:0]   env_div    = '0;
   logic [NIB_W-1:0]   env_level  = '0;
   logic [NIB_W-1:0]   env_volume = '0;
   logic [LEN_W-1:0]   len_left   = '0;
   logic               inv_on     = 1'b0;
   logic [MIX_W-1:0]   sum_l      = '0;
   logic [MIX_W-1:0]   sum_r      = '0;

   chan_req_type   pending[$];
   mix_pair_type   mix_expected[$];
   chan_req_type   req_shown;
   mix_pair_type   mix_want;
   int          last_busy = 0;
   int          send_gap = 0;
   bit          send_burst = 1'b0;
   int          recv_gap = 0;
   bit          recv_burst = 1'b0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;

   square_wave_channel_with_envelope i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_tick_count   (req_tick_count),
      .req_mix_enable   (req_mix_enable),
      .req_length_value (req_length_value),
      .req_downsample   (req_downsample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mix_left     (rsp_mix_left),
      .rsp_mix_right    (rsp_mix_right),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the channel copy by one request; queue the mix a read returns
   function automatic void advance_channel(input chan_req_type rq);
      logic [NIB_W-1:0]   vol;
      logic [TICK_W-1:0]  remain;
      logic [TIMER_W-1:0] seg;
      logic [MIX_W-1:0]   add;
      longint             divisor;
      int                 l_s;
      int                 r_s;
      longint             q_l;
      longint             q_r;
      mix_pair_type       want;
      vol = cfg_env_mode[1] ? env_volume : cfg_fixed_vol;
      case (rq.command)
         CMD_TICKS: begin
            if (cfg_period >= SILENT_BELOW) begin
               remain = rq.tick_count;
               // walk the batch one timer segment at a time
               while (remain != 0) begin
                  seg = (timer_left < remain) ? timer_left : TIMER_W'(remain);
                  remain = remain - TICK_W'(seg);
                  timer_left = timer_left - seg;
                  if (rq.mix_enable && duty_pos < cfg_duty_thr && len_left != 0) begin
                     add = MIX_W'(vol) * MIX_W'(seg);
                     sum_l = sum_l + add;
                     if (inv_on)
                        sum_r = sum_r - add;
                     else
                        sum_r = sum_r + add;
                  end
                  if (timer_left == 0) begin
                     timer_left = {1'b0, cfg_period} + TIMER_W'(1);
                     duty_pos = duty_pos + NIB_W'(1);
                     // latch inversion at duty wrap
                     if (duty_pos == 0)
                        inv_on = cfg_inv_req && !(cfg_inv_cutoff < cfg_period);
                  end
               end
            end
         end
         CMD_ENV_CLK: begin
            if (env_div != 0) begin
               env_div = env_div - NIB_W'(1);
            end else begin
               env_div = cfg_env_period;
               if (env_level != 0)
                  env_level = env_level - NIB_W'(1);
               else if (cfg_env_mode[0])
                  env_level = LEVEL_MAX;
               if (cfg_env_mode[1])
                  env_volume = env_level;
            end
         end
         CMD_LEN_CLK: begin
            if (cfg_len_en && len_left != 0)
               len_left = len_left - LEN_W'(1);
         end
         CMD_LEN_LOAD: len_left = rq.length_value;
         CMD_READ: begin
            divisor = (rq.downsample == 0) ? 64'sd1 : longint'(rq.downsample);
            l_s = sum_l;
            r_s = sum_r;
            q_l = longint'(l_s) / divisor;
            q_r = longint'(r_s) / divisor;
            want.left  = q_l[MIX_W-1:0];
            want.right = q_r[MIX_W-1:0];
            mix_expected.push_back(want);
            sum_l = '0;
            sum_r = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void push_request(input logic [CMD_W-1:0] cmd, input int unsigned ticks,
                                        input bit mix, input int unsigned len,
                                        input int unsigned ds);
      chan_req_type rq;
      rq.command      = cmd;
      rq.tick_count   = TICK_W'(ticks);
      rq.mix_enable   = mix;
      rq.length_value = LEN_W'(len);
      rq.downsample   = DS_W'(ds);
      pending.push_back(rq);
   endfunction

   function automatic int unsigned pick_extreme(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(0, 4))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // Queue one random request; return 1 when the block acts on it
   function automatic bit push_random_request();
      chan_req_type rq;
      int unsigned  roll;
      int unsigned  cap;
      rq.command      = CMD_TICKS;
      rq.tick_count   = TICK_W'($urandom);
      rq.mix_enable   = ($urandom_range(0, 6) != 0);
      rq.length_value = LEN_W'($urandom);
      rq.downsample   = DS_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         // keep most batches to a few dozen timer wraps
         cap = (int'(cfg_period) + 1) * 40;
         if (cap > 65535)
            cap = 65535;
         case ($urandom_range(0, 39))
            0:       rq.tick_count = '1;
            1:       ;
            2, 3:    rq.tick_count = TICK_W'($urandom_range(0, 3));
            default: rq.tick_count = TICK_W'($urandom_range(0, cap));
         endcase
      end else if (roll < 60) begin
         rq.command = CMD_ENV_CLK;
      end else if (roll < 70) begin
         rq.command = CMD_LEN_CLK;
      end else if (roll < 79) begin
         rq.command = CMD_LEN_LOAD;
         rq.length_value = LEN_W'(pick_extreme(0, 255));
      end else if (roll < 95) begin
         rq.command = CMD_READ;
         case ($urandom_range(0, 19))
            0:             rq.downsample = '0;
            1:             rq.downsample = '1;
            2, 3, 4, 5, 6: ;
            default:       rq.downsample = DS_W'($urandom_range(1, 16));
         endcase
      end else begin
         rq.command = CMD_SPARE_LO + CMD_W'($urandom_range(0, 2));
      end
      pending.push_back(rq);
      return rq.command <= CMD_READ;
   endfunction

   task automatic write_reg(input logic [CSR_IX_W-1:0] ix, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= ix;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (ix)
         CSR_PERIOD:     cfg_period     = PER_W'(value);
         CSR_DUTY_THR:   cfg_duty_thr   = NIB_W'(value);
         CSR_ENV_PERIOD: cfg_env_period = NIB_W'(value);
         CSR_ENV_MODE:   cfg_env_mode   = MODE_W'(value);
         CSR_LEN_EN:     cfg_len_en     = value[0];
         CSR_INV_REQ:    cfg_inv_req    = value[0];
         CSR_INV_CUTOFF: cfg_inv_cutoff = PER_W'(value);
         CSR_FIXED_VOL:  cfg_fixed_vol  = NIB_W'(value);
         default: ;
      endcase
   endtask

   // Wait until every request is taken and every mix is back, then let the last one finish
   task automatic settle_channel();
      do
         @(negedge clock);
      while (pending.size() != 0 || req_valid || mix_expected.size() != 0);
      repeat (last_busy) @(posedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_channel(req_shown);
            if (req_shown.command == CMD_TICKS)
               last_busy = 2 * (2 + int'(req_shown.tick_count) / (int'(cfg_period) + 1)) + 16;
            else
               last_busy = 100;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               req_shown = pending.pop_front();
               req_command      <= req_shown.command;
               req_tick_count   <= req_shown.tick_count;
               req_mix_enable   <= req_shown.mix_enable;
               req_length_value <= req_shown.length_value;
               req_downsample   <= req_shown.downsample;
               req_valid        <= 1'b1;
               // switch now and then between back-to-back and gapped requests
               if ($urandom_range(0, 31) == 0)
                  send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Mix monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mix_expected.size() == 0) begin
               $display("%0t: mix response with no read outstanding, got %0d / %0d",
                        $time, rsp_mix_left, rsp_mix_right);
               mismatches++;
            end else begin
               mix_want = mix_expected.pop_front();
               if (rsp_mix_left !== mix_want.left) begin
                  $display("%0t: mix_left expected %0d, got %0d",
                           $time, $signed(mix_want.left), rsp_mix_left);
                  mismatches++;
               end
               if (rsp_mix_right !== mix_want.right) begin
                  $display("%0t: mix_right expected %0d, got %0d",
                           $time, $signed(mix_want.right), rsp_mix_right);
                  mismatches++;
               end
            end
            results_seen++;
            // hold off long enough that the block backs up onto its input
            if (results_seen == 25 || results_seen == 180) begin
               recv_gap = LONG_HOLD;
            end else begin
               if ($urandom_range(0, 31) == 0)
                  recv_burst = !recv_burst;
               recv_gap = recv_burst ? 0 : $urandom_range(0, 6);
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned taken;
      int unsigned per_pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset leaves the period at zero: batches are silent, reads return zero
      push_request(CMD_TICKS, 16'hFFFF, 1'b1, 0, 1);
      push_request(CMD_LEN_LOAD, 0, 1'b0, 8'hFF, 0);
      push_request(CMD_TICKS, 16'h1234, 1'b1, 0, 0);
      push_request(CMD_READ, 0, 1'b0, 0, 0);
      push_request(CMD_SPARE_LO, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
      push_request(CMD_SPARE_HI, 0, 1'b0, 0, 1);
      settle_channel();

      // shortest audible period, envelope volume with loop, inversion on
      write_reg(CSR_PERIOD, 8);
      write_reg(CSR_DUTY_THR, 15);
      write_reg(CSR_ENV_PERIOD, 0);
      write_reg(CSR_ENV_MODE, 3);
      write_reg(CSR_LEN_EN, 1);
      write_reg(CSR_INV_REQ, 1);
      write_reg(CSR_INV_CUTOFF, 2047);
      write_reg(CSR_FIXED_VOL, 15);
      push_request(CMD_ENV_CLK, 0, 1'b0, 0, 0);
      push_request(CMD_ENV_CLK, 0, 1'b0, 0, 0);
      push_request(CMD_TICKS, 16'hFFFF, 1'b1, 0, 0);
      push_request(CMD_READ, 0, 1'b0, 0, 16'hFFFF);
      push_request(CMD_TICKS, 0, 1'b1, 0, 0);
      push_request(CMD_TICKS, 1000, 1'b0, 0, 0);
      push_request(CMD_LEN_CLK, 0, 1'b0, 0, 0);
      push_request(CMD_TICKS, 500, 1'b1, 0, 0);
      push_request(CMD_READ, 0, 1'b0, 0, 1);
      push_request(CMD_LEN_LOAD, 0, 1'b0, 1, 0);
      push_request(CMD_LEN_CLK, 0, 1'b0, 0, 0);
      push_request(CMD_TICKS, 300, 1'b1, 0, 0);
      push_request(CMD_READ, 0, 1'b0, 0, 3);
      settle_channel();

      // longest period above the cutoff: inversion drops at the next duty wrap
      write_reg(CSR_PERIOD, 2047);
      write_reg(CSR_INV_CUTOFF, 0);
      write_reg(CSR_ENV_MODE, 0);
      push_request(CMD_LEN_LOAD, 0, 1'b0, 8'hFF, 0);
      push_request(CMD_TICKS, 16'hFFFF, 1'b1, 0, 0);
      push_request(CMD_TICKS, 16'hFFFF, 1'b1, 0, 0);
      push_request(CMD_READ, 0, 1'b0, 0, 16'h8000);
      settle_channel();

      // random phases, each under a fresh register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0:       per_pick = $urandom_range(0, 7);
            1:       per_pick = 8;
            2:       per_pick = 2047;
            default: per_pick = $urandom_range(8, 2047);
         endcase
         write_reg(CSR_PERIOD, per_pick);
         write_reg(CSR_DUTY_THR, pick_extreme(0, 15));
         write_reg(CSR_ENV_PERIOD, pick_extreme(0, 15));
         write_reg(CSR_ENV_MODE, $urandom_range(0, 3));
         write_reg(CSR_LEN_EN, $urandom_range(0, 1));
         write_reg(CSR_INV_REQ, $urandom_range(0, 1));
         write_reg(CSR_INV_CUTOFF, pick_extreme(0, 2047));
         write_reg(CSR_FIXED_VOL, pick_extreme(0, 15));
         // open with a loaded length counter so the channel can sound
         push_request(CMD_LEN_LOAD, 0, 1'b0, $urandom_range(1, 255), 0);
         taken = 1;
         while (taken < PHASE_REQUESTS)
            taken += push_random_request();
         settle_channel();
      end

      if (mismatches == 0)
         $display("** square_wave_channel_with_envelope: PASSED **");
      else
         $display("** square_wave_channel_with_envelope: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("** square_wave_channel_with_envelope: FAILED **");
      $finish;
   end

endmodule
